>>> hw/rtl/fir_filter_circular_delay_line_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef FIR_FILTER_CIRCULAR_DELAY_LINE_MACROS_SVH
`define FIR_FILTER_CIRCULAR_DELAY_LINE_MACROS_SVH

`ifndef SYNTHESIS
`define FCDL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fcdl assertion failed");
`define FCDL_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("fcdl forbidden condition");
`else
`define FCDL_ASSERT(label, prop)
`define FCDL_ASSERT_NEVER(label, cond)
`endif

`endif

>>> hw/rtl/fcdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcdl_pkg;

	localparam int MAX_TAPS_DEF    = 128;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF   = 18;
	localparam int TAP_INDEX_BITS  = 7;
	localparam int TAP_COUNT_BITS  = 8;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/fir_filter_circular_delay_line.sv
// A sample transaction walks the n taps in use (n = taps in use) through the single MAC and the two memories (ST_MAC),
//   drains the multiply pipeline (ST_DRAIN) and is rounded (ST_ROUND); only then is new input taken (ST_IDLE).
//   ST_ROUND holds while the previous result has not been taken.
// Reset: asynchronous, active low; tap count 1, write position 0. After reset the delay line
//   memory is cleared one entry per cycle, during which no input is taken.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_circular_delay_line #(
	parameter int MAX_TAPS    = fcdl_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcdl_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = fcdl_pkg::COEF_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic                                  cfg_we,
	input  wire logic [fcdl_pkg::TAP_COUNT_BITS-1:0]   cfg_wdata,  // tap_count

	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	// tap_index, coefficient, sample_in
	input  wire logic [((fcdl_pkg::TAP_INDEX_BITS+COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0]
	                                                   s_axis_tdata,
	input  wire logic                                  s_axis_tuser,  // action

	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output      logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata   // sample_out
);

	import fcdl_pkg::*;

`include "fir_filter_circular_delay_line_macros.svh"

	localparam int ADDR_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W      = $clog2(MAX_TAPS + 1);
	localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_FULL   = PROD_W + $clog2(MAX_TAPS);
	localparam int ACC_W      = (ACC_FULL > 64) ? 64 : ACC_FULL;
	localparam int SH_W       = ACC_W - COEF_BITS + 1;
	localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	// input fields
	logic [TAP_INDEX_BITS-1:0]    in_tap_index;
	logic signed [COEF_BITS-1:0]  in_coef;
	logic signed [SAMPLE_BITS-1:0] in_sample;

	assign in_tap_index = s_axis_tdata[TAP_INDEX_BITS-1:0];
	assign in_coef      = s_axis_tdata[TAP_INDEX_BITS +: COEF_BITS];
	assign in_sample    = s_axis_tdata[TAP_INDEX_BITS+COEF_BITS +: SAMPLE_BITS];

	state_t state_q, state_d;

	logic [TAP_COUNT_BITS-1:0] tap_count_q;
	logic [ADDR_W-1:0]         wp_q;
	logic [ADDR_W-1:0]         rd_ptr_q;
	logic [ADDR_W-1:0]         tap_ptr_q;
	logic [ADDR_W-1:0]         clr_idx_q;

	logic signed [SAMPLE_BITS-1:0] dl_mem  [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   tap_mem [MAX_TAPS];

	logic signed [SAMPLE_BITS-1:0] dl_rd_s1;
	logic signed [COEF_BITS-1:0]   tap_rd_s1;
	logic                          valid_s1, last_s1;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          valid_s2, last_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_q;

	// FSM outputs
	logic in_ready, issue, out_load, clr_we;

	// effective tap count
	logic [31:0]      n32;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] n_m1;

	always_comb begin
		if (tap_count_q == '0) begin
			n32 = 32'd1;
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			n32 = 32'(MAX_TAPS);
		end else begin
			n32 = 32'(tap_count_q);
		end
	end

	assign n    = n32[CNT_W-1:0];
	assign n_m1 = n - CNT_W'(1);

	logic            in_xfer, load_xfer, sample_xfer;
	logic [ADDR_W:0] wp_inc;
	logic [ADDR_W-1:0] wp_next;
	logic            tap_last;
	logic [31:0]     idx32;
	logic            load_in_range;

	assign in_xfer     = s_axis_tvalid && s_axis_tready;
	assign load_xfer   = in_xfer && (s_axis_tuser == ACT_LOAD);
	assign sample_xfer = in_xfer && (s_axis_tuser == ACT_SAMPLE);

	assign wp_inc  = {1'b0, wp_q} + (ADDR_W+1)'(1);
	assign wp_next = (32'(wp_inc) >= 32'(n)) ? '0 : wp_inc[ADDR_W-1:0];

	assign tap_last = (32'(tap_ptr_q) == 32'(n_m1));

	assign idx32         = 32'(in_tap_index);
	assign load_in_range = idx32 < 32'(MAX_TAPS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_idx_q) == 32'(MAX_TAPS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sample_xfer) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (tap_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		clr_we   = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr_we   = 1'b1;
			ST_IDLE:  in_ready = 1'b1;
			ST_MAC:   issue    = 1'b1;
			ST_DRAIN: ;
			ST_ROUND: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign s_axis_tready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			tap_count_q <= TAP_COUNT_BITS'(1);
			wp_q        <= '0;
			clr_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tap_count_q <= cfg_wdata;
			if (clr_we) clr_idx_q <= clr_idx_q + ADDR_W'(1);
			if (sample_xfer) wp_q <= wp_next;
		end
	end

	// walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			tap_ptr_q <= '0;
		end else if (sample_xfer) begin
			rd_ptr_q  <= wp_next;
			tap_ptr_q <= '0;
		end else if (issue) begin
			rd_ptr_q  <= (rd_ptr_q == '0) ? ADDR_W'(n_m1) : rd_ptr_q - ADDR_W'(1);
			tap_ptr_q <= tap_ptr_q + ADDR_W'(1);
		end
	end

	// delay line memory
	always_ff @(posedge clk) begin
		if (clr_we) begin
			dl_mem[clr_idx_q] <= '0;
		end else if (sample_xfer) begin
			dl_mem[wp_next] <= in_sample;
		end
	end

	always_ff @(posedge clk) begin
		dl_rd_s1 <= dl_mem[rd_ptr_q];
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (load_xfer && load_in_range) begin
			tap_mem[idx32[ADDR_W-1:0]] <= in_coef;
		end
	end

	always_ff @(posedge clk) begin
		tap_rd_s1 <= tap_mem[tap_ptr_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= dl_rd_s1 * tap_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= issue && tap_last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up, then saturate
	logic signed [ACC_W-1:0]        acc_rnd;
	logic signed [SH_W-1:0]         acc_sh;
	logic [SH_W-SAMPLE_BITS:0]      acc_hi;
	logic [SAMPLE_BITS-1:0]         sat_val;

	assign acc_rnd = acc_q + (ACC_W'(1) << (COEF_BITS - 2));
	assign acc_sh  = acc_rnd[ACC_W-1:COEF_BITS-1];
	assign acc_hi  = acc_sh[SH_W-1:SAMPLE_BITS-1];

	always_comb begin
		if (&acc_hi || ~|acc_hi) begin
			sat_val = acc_sh[SAMPLE_BITS-1:0];
		end else if (acc_sh[SH_W-1]) begin
			sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= sat_val;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_q);

	`FCDL_ASSERT(a_rd_ptr_in_line, (state_q == ST_MAC) |-> (32'(rd_ptr_q) < 32'(n)))
	`FCDL_ASSERT(a_round_after_drain,
		(state_q == ST_ROUND) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_ROUND))
	`FCDL_ASSERT_NEVER(a_no_issue_while_ready, issue && s_axis_tready)
	`FCDL_ASSERT(a_sample_blocks_input, sample_xfer |=> !s_axis_tready)

endmodule

`default_nettype wire
